/* src/crs_pkg.sv */
// crs_pkg: shared types and constants of the crystal range select readout
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package crs_pkg;

    localparam int FRAC_BITS  = 4;
    localparam int NUM_RANGES = 4;
    localparam int RNG_W      = 2;
    localparam int NUM_SLOTS  = 2 * NUM_RANGES;
    localparam int SLOT_W     = 3;

    localparam int ADC_IN_W   = 17;
    localparam int PED_W      = 16;
    localparam int ULD_W      = 16;
    localparam int CIDAC_W    = 20;
    localparam int CNT_W      = 12;

    // clamp ceiling is max_adc in fixed point
    localparam int CEIL_W     = CNT_W + FRAC_BITS;
    localparam int SUM_W      = (CEIL_W + 1 > ADC_IN_W + 2) ? CEIL_W + 1 : ADC_IN_W + 2;
    localparam int HALF       = (1 << FRAC_BITS) / 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int MODE_W     = 3;

    // range codes
    localparam logic [RNG_W-1:0] RNG_LEX8 = 2'd0;
    localparam logic [RNG_W-1:0] RNG_HEX8 = 2'd2;
    localparam logic [RNG_W-1:0] RNG_HEX1 = 2'd3;

    // range_mode codes
    localparam logic [MODE_W-1:0] MODE_FORCE_FIRST = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FORCE_LAST  = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_MODE    = 3'd0,
        REG_ALL_RANGE     = 3'd1,
        REG_ZERO_SUPPRESS = 3'd2,
        REG_MAX_ADC       = 3'd3,
        REG_FAIL_CHECK    = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_RD_POS,
        ST_RD_NEG
    } state_t;

    typedef struct packed {
        logic signed [ADC_IN_W-1:0] adc;
        logic [PED_W-1:0]           ped;
        logic [ULD_W-1:0]           uld;
    } slot_t;

    typedef struct packed {
        logic [MODE_W-1:0] range_mode;
        logic              all_range;
        logic              zero_suppress;
        logic [CNT_W-1:0]  max_adc;
        logic              fail_check;
    } cfg_t;

endpackage

`default_nettype wire

/* src/crs_store.sv */
// crs_store: sample memory, one entry per face and range
// depends on crs_pkg; one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module crs_store (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [crs_pkg::SLOT_W-1:0] wr_addr,
    input  wire crs_pkg::slot_t           wr_data,
    input  wire logic [crs_pkg::SLOT_W-1:0] rd_addr,
    output crs_pkg::slot_t                rd_data
);
    import crs_pkg::*;

    slot_t slot_mem [NUM_SLOTS];
    slot_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= slot_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/crs_unit.sv */
// crs_unit: shared compare and readout arithmetic
// depends on crs_pkg; uld compare, hex1 clip, pedestal add, clamp and rounding
`timescale 1ns / 1ps
`default_nettype none

module crs_unit (
    input  wire crs_pkg::slot_t             data,
    input  wire logic                       clip,
    input  wire logic [crs_pkg::CNT_W-1:0]  max_adc,
    output logic                            le,
    output logic [crs_pkg::CNT_W-1:0]       count
);
    import crs_pkg::*;

    logic signed [ADC_IN_W:0] adc_x;
    logic signed [ADC_IN_W:0] uld_x;
    logic signed [ADC_IN_W:0] eff;
    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]         ceil_u;
    logic [CEIL_W-1:0]        clamped;
    logic [CEIL_W:0]          rounded;

    always_comb begin
        adc_x   = {data.adc[ADC_IN_W-1], data.adc};
        uld_x   = signed'({{(ADC_IN_W + 1 - ULD_W){1'b0}}, data.uld});
        le      = (adc_x <= uld_x);
        // hex1 reading at or over its uld is pinned to the uld
        eff     = (clip && !(adc_x < uld_x)) ? uld_x : adc_x;
        sum     = SUM_W'(eff) + SUM_W'(signed'({1'b0, data.ped}));
        ceil_u  = SUM_W'(max_adc) << FRAC_BITS;
        if (sum[SUM_W-1]) begin
            clamped = '0;
        end else if (sum > signed'(ceil_u)) begin
            clamped = ceil_u[CEIL_W-1:0];
        end else begin
            clamped = sum[CEIL_W-1:0];
        end
        rounded = {1'b0, clamped} + (CEIL_W + 1)'(HALF);
        count   = CNT_W'(rounded >> FRAC_BITS);
    end

endmodule

`default_nettype wire

/* src/crs_seq.sv */
// crs_seq: sequencer with lac/dead flags, range scan and readout output register
// depends on crs_pkg; drives the read port of crs_store and the inputs of crs_unit
`timescale 1ns / 1ps
`default_nettype none

module crs_seq (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire crs_pkg::cfg_t                cfg,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_face,
    input  wire logic [crs_pkg::RNG_W-1:0]    s_adc_range,
    input  wire logic [crs_pkg::CIDAC_W-1:0]  s_diode_signal,
    input  wire logic [crs_pkg::CIDAC_W-1:0]  s_lac_threshold,
    input  wire logic                         s_channel_dead,
    input  wire logic                         s_last_sample,
    output logic [crs_pkg::SLOT_W-1:0]        rd_addr,
    output logic                              unit_clip,
    input  wire logic                         unit_le,
    input  wire logic [crs_pkg::CNT_W-1:0]    unit_count,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [crs_pkg::RNG_W-1:0]         m_pos_range,
    output logic [crs_pkg::CNT_W-1:0]         m_pos_adc,
    output logic [crs_pkg::RNG_W-1:0]         m_neg_range,
    output logic [crs_pkg::CNT_W-1:0]         m_neg_adc,
    output logic                              m_dead_pos,
    output logic                              m_dead_neg,
    output logic                              m_ok_pos,
    output logic                              m_ok_neg,
    output logic                              m_lac_pos,
    output logic                              m_lac_neg,
    output logic                              m_last_readout
);
    import crs_pkg::*;

    typedef struct packed {
        logic [RNG_W-1:0] pos_range;
        logic [CNT_W-1:0] pos_adc;
        logic [RNG_W-1:0] neg_range;
        logic [CNT_W-1:0] neg_adc;
        logic [1:0]       dead;
        logic [1:0]       ok;
        logic [1:0]       lac;
        logic             last;
    } readout_t;

    state_t           state_reg, state_next;
    logic             face_reg, face_next;
    logic [RNG_W-1:0] rng_reg, rng_next;
    logic [RNG_W-1:0] n_reg, n_next;
    logic [RNG_W-1:0] sel0_reg, sel0_next;
    logic [RNG_W-1:0] sel1_reg, sel1_next;
    logic [1:0]       clip_reg, clip_next;
    logic [1:0]       lac_reg, lac_next;
    logic [1:0]       dead_reg, dead_next;
    logic [1:0]       st_dead_reg, st_dead_next;
    logic [1:0]       st_ok_reg, st_ok_next;
    logic [CNT_W-1:0] pos_hold_reg, pos_hold_next;
    logic             m_valid_reg, m_valid_next;
    readout_t         out_reg, out_next;

    logic             accept;
    logic             out_free;
    logic             forced;
    logic [RNG_W-1:0] last_idx;
    logic [RNG_W-1:0] rp;
    logic [RNG_W-1:0] rn;
    logic [RNG_W-1:0] chosen;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            lac_reg     <= '0;
            dead_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lac_reg     <= lac_next;
            dead_reg    <= dead_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        face_reg     <= face_next;
        rng_reg      <= rng_next;
        n_reg        <= n_next;
        sel0_reg     <= sel0_next;
        sel1_reg     <= sel1_next;
        clip_reg     <= clip_next;
        st_dead_reg  <= st_dead_next;
        st_ok_reg    <= st_ok_next;
        pos_hold_reg <= pos_hold_next;
        out_reg      <= out_next;
    end

    always_comb begin
        state_next    = state_reg;
        face_next     = face_reg;
        rng_next      = rng_reg;
        n_next        = n_reg;
        sel0_next     = sel0_reg;
        sel1_next     = sel1_reg;
        clip_next     = clip_reg;
        lac_next      = lac_reg;
        dead_next     = dead_reg;
        st_dead_next  = st_dead_reg;
        st_ok_next    = st_ok_reg;
        pos_hold_next = pos_hold_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg;
        unit_clip     = 1'b0;
        chosen        = RNG_HEX1;

        s_ready  = (state_reg == ST_IDLE);
        accept   = s_valid && s_ready;
        out_free = !m_valid_reg || m_ready;
        forced   = (cfg.range_mode >= MODE_FORCE_FIRST) && (cfg.range_mode <= MODE_FORCE_LAST);
        last_idx = cfg.all_range ? RNG_W'(NUM_RANGES - 1) : '0;
        rp       = sel0_reg + n_reg;
        rn       = sel1_reg + n_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // lex8 word of a face refreshes its lac and dead bits
        if (accept && (s_adc_range == RNG_LEX8)) begin
            lac_next[s_face]  = (s_diode_signal >= s_lac_threshold);
            dead_next[s_face] = s_channel_dead;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept && s_last_sample) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (cfg.zero_suppress && (lac_reg == 2'b00)) begin
                    state_next = ST_IDLE;
                end else begin
                    if (cfg.fail_check) begin
                        st_dead_next = dead_reg & lac_reg;
                        st_ok_next   = ~(dead_reg & lac_reg);
                    end else begin
                        st_dead_next = '0;
                        st_ok_next   = '0;
                    end
                    n_next = '0;
                    if (forced) begin
                        sel0_next  = RNG_W'(cfg.range_mode - MODE_FORCE_FIRST);
                        sel1_next  = RNG_W'(cfg.range_mode - MODE_FORCE_FIRST);
                        clip_next  = '0;
                        state_next = ST_RD_POS;
                    end else begin
                        face_next  = 1'b0;
                        rng_next   = RNG_LEX8;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // lowest of lex8..hex8 inside its uld, else hex1 with clipping
                if (unit_le || (rng_reg == RNG_HEX8)) begin
                    chosen = unit_le ? rng_reg : RNG_HEX1;
                    if (!face_reg) begin
                        sel0_next   = chosen;
                        clip_next[0] = !unit_le;
                        face_next   = 1'b1;
                        rng_next    = RNG_LEX8;
                    end else begin
                        sel1_next   = chosen;
                        clip_next[1] = !unit_le;
                        state_next  = ST_RD_POS;
                    end
                end else begin
                    rng_next = rng_reg + 1'b1;
                end
            end
            ST_RD_POS: begin
                unit_clip     = clip_reg[0] && (rp == RNG_HEX1);
                pos_hold_next = unit_count;
                state_next    = ST_RD_NEG;
            end
            ST_RD_NEG: begin
                unit_clip = clip_reg[1] && (rn == RNG_HEX1);
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    out_next.pos_range = rp;
                    out_next.pos_adc   = pos_hold_reg;
                    out_next.neg_range = rn;
                    out_next.neg_adc   = unit_count;
                    out_next.dead      = st_dead_reg;
                    out_next.ok        = st_ok_reg;
                    out_next.lac       = lac_reg;
                    out_next.last      = (n_reg == last_idx);
                    if (n_reg == last_idx) begin
                        state_next = ST_IDLE;
                    end else begin
                        n_next     = n_reg + 1'b1;
                        state_next = ST_RD_POS;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // read address follows the next step so data is ready on arrival
        case (state_next)
            ST_SCAN:   rd_addr = {face_next, rng_next};
            ST_RD_POS: rd_addr = {1'b0, sel0_next + n_next};
            ST_RD_NEG: rd_addr = {1'b1, sel1_next + n_next};
            default:   rd_addr = '0;
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_pos_range    = out_reg.pos_range;
    assign m_pos_adc      = out_reg.pos_adc;
    assign m_neg_range    = out_reg.neg_range;
    assign m_neg_adc      = out_reg.neg_adc;
    assign m_dead_pos     = out_reg.dead[0];
    assign m_dead_neg     = out_reg.dead[1];
    assign m_ok_pos       = out_reg.ok[0];
    assign m_ok_neg       = out_reg.ok[1];
    assign m_lac_pos      = out_reg.lac[0];
    assign m_lac_neg      = out_reg.lac[1];
    assign m_last_readout = out_reg.last;

    a_rise_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_RD_NEG)
        else $error("readout word appeared without a load");

    a_dead_ok_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(out_reg.dead[0] && out_reg.ok[0]) && !(out_reg.dead[1] && out_reg.ok[1]))
        else $error("dead and ok both set on one face");

    a_dead_needs_lac: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!out_reg.dead[0] || out_reg.lac[0]) && (!out_reg.dead[1] || out_reg.lac[1]))
        else $error("dead flag without lac hit");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> rng_reg != RNG_HEX1)
        else $error("scan went past hex8");

endmodule

`default_nettype wire

/* src/crystal_adc_range_select_readout.sv */
// crystal_adc_range_select_readout: top level, config registers and wiring
// depends on crs_pkg, crs_store, crs_unit and crs_seq
//
//   channel   prefix   handshake            word
//   sample    s_       s_valid / s_ready    one face/range sample
//   readout   m_       m_valid / m_ready    one readout of both faces
//   config    cfg_     cfg_valid/cfg_ready  register index and data
//
// samples not marked last are taken back to back while s_ready stays high.
// after a last sample: the lac check state (suppressed crystals end there),
// then one compare per range in automatic mode (1 to 3 per face), then per
// readout a pos step and a neg step through the shared arithmetic unit.
// a finished readout waits in the output register; the next sample is taken
// meanwhile, and the sequencer stalls only when a second readout is ready.
// reset is synchronous, active low; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module crystal_adc_range_select_readout (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_face,
    input  wire logic [crs_pkg::RNG_W-1:0]         s_adc_range,
    input  wire logic signed [crs_pkg::ADC_IN_W-1:0] s_adc_above_ped,
    input  wire logic [crs_pkg::PED_W-1:0]         s_pedestal,
    input  wire logic [crs_pkg::ULD_W-1:0]         s_uld_threshold,
    input  wire logic [crs_pkg::CIDAC_W-1:0]       s_diode_signal,
    input  wire logic [crs_pkg::CIDAC_W-1:0]       s_lac_threshold,
    input  wire logic                              s_channel_dead,
    input  wire logic                              s_last_sample,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [crs_pkg::RNG_W-1:0]              m_pos_range,
    output logic [crs_pkg::CNT_W-1:0]              m_pos_adc,
    output logic [crs_pkg::RNG_W-1:0]              m_neg_range,
    output logic [crs_pkg::CNT_W-1:0]              m_neg_adc,
    output logic                                   m_dead_pos,
    output logic                                   m_dead_neg,
    output logic                                   m_ok_pos,
    output logic                                   m_ok_neg,
    output logic                                   m_lac_pos,
    output logic                                   m_lac_neg,
    output logic                                   m_last_readout,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [crs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [crs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import crs_pkg::*;

    cfg_t              cfg_reg;
    slot_t             wr_sample;
    slot_t             rd_sample;
    logic [SLOT_W-1:0] rd_addr;
    logic              unit_clip;
    logic              unit_le;
    logic [CNT_W-1:0]  unit_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_mode    <= '0;
            cfg_reg.all_range     <= 1'b0;
            cfg_reg.zero_suppress <= 1'b1;
            cfg_reg.max_adc       <= '1;
            cfg_reg.fail_check    <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_RANGE_MODE:    cfg_reg.range_mode    <= cfg_data[MODE_W-1:0];
                REG_ALL_RANGE:     cfg_reg.all_range     <= cfg_data[0];
                REG_ZERO_SUPPRESS: cfg_reg.zero_suppress <= cfg_data[0];
                REG_MAX_ADC:       cfg_reg.max_adc       <= cfg_data[CNT_W-1:0];
                REG_FAIL_CHECK:    cfg_reg.fail_check    <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        wr_sample.adc = s_adc_above_ped;
        wr_sample.ped = s_pedestal;
        wr_sample.uld = s_uld_threshold;
    end

    crs_store u_store (
        .aclk    (aclk),
        .wr_en   (s_valid && s_ready),
        .wr_addr ({s_face, s_adc_range}),
        .wr_data (wr_sample),
        .rd_addr (rd_addr),
        .rd_data (rd_sample)
    );

    crs_unit u_unit (
        .data    (rd_sample),
        .clip    (unit_clip),
        .max_adc (cfg_reg.max_adc),
        .le      (unit_le),
        .count   (unit_count)
    );

    crs_seq u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_face          (s_face),
        .s_adc_range     (s_adc_range),
        .s_diode_signal  (s_diode_signal),
        .s_lac_threshold (s_lac_threshold),
        .s_channel_dead  (s_channel_dead),
        .s_last_sample   (s_last_sample),
        .rd_addr         (rd_addr),
        .unit_clip       (unit_clip),
        .unit_le         (unit_le),
        .unit_count      (unit_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pos_range     (m_pos_range),
        .m_pos_adc       (m_pos_adc),
        .m_neg_range     (m_neg_range),
        .m_neg_adc       (m_neg_adc),
        .m_dead_pos      (m_dead_pos),
        .m_dead_neg      (m_dead_neg),
        .m_ok_pos        (m_ok_pos),
        .m_ok_neg        (m_ok_neg),
        .m_lac_pos       (m_lac_pos),
        .m_lac_neg       (m_lac_neg),
        .m_last_readout  (m_last_readout)
    );

endmodule

`default_nettype wire
